@@ hw/rtl/register_pmachine_executor_core_assert.svh @@
// Assertion macros for the stack machine executor core.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef REGISTER_PMACHINE_EXECUTOR_CORE_ASSERT_SVH
`define REGISTER_PMACHINE_EXECUTOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define RPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define RPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rpe_pkg
// Types, opcodes and constants shared by the executor core and its divider.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int STACK_AW = 11;
  localparam int CODE_AW  = 9;
  localparam int REG_AW   = 4;
  localparam int REG_COUNT = 16;
  localparam int WORD_W   = 32;

  localparam logic [STACK_AW-1:0] STACK_LAST = 11'd2047;
  localparam logic [STACK_AW-1:0] CAL_SP_MAX = 11'd2043;
  localparam logic [STACK_AW-1:0] RTN_BP_MAX = 11'd2044;

  // Opcodes
  localparam logic [4:0] OP_LIT  = 5'd1;
  localparam logic [4:0] OP_RTN  = 5'd2;
  localparam logic [4:0] OP_LOD  = 5'd3;
  localparam logic [4:0] OP_STO  = 5'd4;
  localparam logic [4:0] OP_CAL  = 5'd5;
  localparam logic [4:0] OP_INC  = 5'd6;
  localparam logic [4:0] OP_JMP  = 5'd7;
  localparam logic [4:0] OP_JPC  = 5'd8;
  localparam logic [4:0] OP_WRT  = 5'd9;
  localparam logic [4:0] OP_RED  = 5'd10;
  localparam logic [4:0] OP_HLT  = 5'd11;
  localparam logic [4:0] OP_NEG  = 5'd12;
  localparam logic [4:0] OP_ADD  = 5'd13;
  localparam logic [4:0] OP_SUB  = 5'd14;
  localparam logic [4:0] OP_MUL  = 5'd15;
  localparam logic [4:0] OP_DIV  = 5'd16;
  localparam logic [4:0] OP_ODD  = 5'd17;
  localparam logic [4:0] OP_MOD  = 5'd18;
  localparam logic [4:0] OP_EQL  = 5'd19;
  localparam logic [4:0] OP_NEQ  = 5'd20;
  localparam logic [4:0] OP_LSS  = 5'd21;
  localparam logic [4:0] OP_LEQ  = 5'd22;
  localparam logic [4:0] OP_GTR  = 5'd23;
  localparam logic [4:0] OP_GEQ  = 5'd24;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DIV0  = 2'd1;
  localparam logic [1:0] FAULT_STACK = 2'd2;

  typedef struct packed {
    logic [4:0]               operation;
    logic [REG_AW-1:0]        reg_index;
    logic [3:0]               level;
    logic signed [WORD_W-1:0] modifier;
    logic signed [WORD_W-1:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic [CODE_AW-1:0]       program_counter;
    logic [STACK_AW-1:0]      base_pointer;
    logic [STACK_AW-1:0]      stack_pointer;
    logic signed [WORD_W-1:0] write_value;
    logic                     write_valid;
    logic                     halted;
    logic [1:0]               fault;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

endpackage

@@ hw/rtl/register_pmachine_executor_core.sv @@
// Sequence: read three register-file words, execute, load the result; LOD, STO
//   and CAL walk one static link per level, CAL adds four stack writes, DIV and
//   MOD wait on the divider, and a beat after halt goes straight to the result.
// Throughput: one instruction at a time, paced by the sequencer, shared adder
//   and stack memory. Reset: synchronous active-low; a pass then clears the
//   stack memory, one word a cycle, before the first beat is accepted.
// ----------------------------------------------------------------------------
// register_pmachine_executor_core
// Executes one fetched instruction per beat against PC, SP, BP, a 16-entry
// register file and a 2048-word stack memory, and returns the new state.
// ----------------------------------------------------------------------------
`include "register_pmachine_executor_core_assert.svh"

module register_pmachine_executor_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpe_pkg::out_item_t out_data
);
  import rpe_pkg::*;

  typedef enum logic [14:0] {
    ST_CLEAR    = 15'h0001,
    ST_IDLE     = 15'h0002,
    ST_RDA      = 15'h0004,
    ST_RDB      = 15'h0008,
    ST_RDR      = 15'h0010,
    ST_EXEC     = 15'h0020,
    ST_WALK_RD  = 15'h0040,
    ST_WALK_CHK = 15'h0080,
    ST_ADDR     = 15'h0100,
    ST_LOD_WAIT = 15'h0200,
    ST_CAL_WR   = 15'h0400,
    ST_RTN_RD3  = 15'h0800,
    ST_RTN_FIN  = 15'h1000,
    ST_DIV      = 15'h2000,
    ST_DONE     = 15'h4000
  } state_t;

  state_t               state_r, state_nxt;
  logic [STACK_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [CODE_AW-1:0]   pc_r, pc_nxt;
  logic [STACK_AW-1:0]  sp_r, sp_nxt, bp_r, bp_nxt;
  logic                 halt_r, halt_nxt;
  logic [WORD_W-1:0]    rf_r [REG_COUNT];

  logic [4:0]           op_r, op_nxt;
  logic [REG_AW-1:0]    ri_r, ri_nxt;
  logic [3:0]           lv_r, lv_nxt;
  logic [WORD_W-1:0]    m_r, m_nxt, rdv_r, rdv_nxt;
  logic [WORD_W-1:0]    a_r, a_nxt, b_r, b_nxt, r_r, r_nxt;
  logic [STACK_AW-1:0]  base_r, base_nxt, nb_r, nb_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [WORD_W-1:0]    wv_r, wv_nxt;
  logic                 wvalid_r, wvalid_nxt;
  logic [1:0]           fault_r, fault_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [REG_AW-1:0]    rf_addr;
  logic [WORD_W-1:0]    rf_rword;
  logic                 rf_we;
  logic [WORD_W-1:0]    rf_wdata;

  logic [WORD_W-1:0]    mem [2**STACK_AW];
  logic [WORD_W-1:0]    mem_q;
  logic                 mem_we, mem_re;
  logic [STACK_AW-1:0]  mem_waddr, mem_raddr;
  logic [WORD_W-1:0]    mem_wdata;

  logic [WORD_W:0]      alu_a, alu_b, alu_sum, sxm;
  logic                 alu_sub;
  logic                 lt, eq, in_rng;
  logic [WORD_W-1:0]    mul_lo;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  rpe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register file read port, one address a cycle
  always_comb begin
    unique case (state_r)
      ST_RDA:  rf_addr = lv_r;
      ST_RDB:  rf_addr = m_r[REG_AW-1:0];
      default: rf_addr = ri_r;
    endcase
  end
  assign rf_rword = rf_r[rf_addr];

  // Shared adder: address sums, INC, NEG, ADD, SUB and compares
  assign sxm = {m_r[WORD_W-1], m_r};
  always_comb begin
    alu_a   = {a_r[WORD_W-1], a_r};
    alu_b   = {b_r[WORD_W-1], b_r};
    alu_sub = 1'b1;
    if (state_r == ST_ADDR) begin
      alu_a   = {22'd0, base_r};
      alu_b   = sxm;
      alu_sub = 1'b0;
    end else if (op_r == OP_INC) begin
      alu_a   = {22'd0, sp_r};
      alu_b   = sxm;
      alu_sub = 1'b0;
    end else if (op_r == OP_NEG) begin
      alu_a   = '0;
      alu_b   = {a_r[WORD_W-1], a_r};
    end else if (op_r == OP_ADD) begin
      alu_sub = 1'b0;
    end
  end
  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {32'd0, alu_sub};
  assign lt      = alu_sum[WORD_W];
  assign eq      = (a_r == b_r);
  assign in_rng  = (alu_sum[WORD_W:STACK_AW] == '0);
  assign mul_lo  = a_r * b_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    pc_nxt        = pc_r;
    sp_nxt        = sp_r;
    bp_nxt        = bp_r;
    halt_nxt      = halt_r;
    op_nxt        = op_r;
    ri_nxt        = ri_r;
    lv_nxt        = lv_r;
    m_nxt         = m_r;
    rdv_nxt       = rdv_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    base_nxt      = base_r;
    nb_nxt        = nb_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    wv_nxt        = wv_r;
    wvalid_nxt    = wvalid_r;
    fault_nxt     = fault_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rf_we         = 1'b0;
    rf_wdata      = '0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    div_req       = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 11'd1;
        if (clr_cnt_r == STACK_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          ri_nxt     = in_data.reg_index;
          lv_nxt     = in_data.level;
          m_nxt      = in_data.modifier;
          rdv_nxt    = in_data.read_value;
          wv_nxt     = '0;
          wvalid_nxt = 1'b0;
          fault_nxt  = FAULT_NONE;
          state_nxt  = halt_r ? ST_DONE : ST_RDA;
        end
      end
      ST_RDA: begin
        a_nxt     = rf_rword;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        b_nxt     = rf_rword;
        state_nxt = ST_RDR;
      end
      ST_RDR: begin
        r_nxt     = rf_rword;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        pc_nxt    = pc_r + 9'd1;
        state_nxt = ST_DONE;
        base_nxt  = bp_r;
        cnt_nxt   = lv_r;
        k_nxt     = '0;
        unique case (op_r)
          OP_LIT: begin
            rf_we = 1'b1; rf_wdata = m_r;
          end
          OP_RTN: begin
            if ((bp_r != '0) && (bp_r <= RTN_BP_MAX)) begin
              mem_re    = 1'b1;
              mem_raddr = bp_r + 11'd2;
              state_nxt = ST_RTN_RD3;
            end else begin
              fault_nxt = FAULT_STACK;
            end
          end
          OP_LOD, OP_STO: state_nxt = ST_WALK_RD;
          OP_CAL: begin
            if (sp_r <= CAL_SP_MAX) begin
              state_nxt = ST_WALK_RD;
            end else begin
              fault_nxt = FAULT_STACK;
            end
          end
          OP_INC: begin
            if (in_rng) begin
              sp_nxt = alu_sum[STACK_AW-1:0];
            end else begin
              fault_nxt = FAULT_STACK;
            end
          end
          OP_JMP: pc_nxt = m_r[CODE_AW-1:0];
          OP_JPC: begin
            if (r_r == '0) begin
              pc_nxt = m_r[CODE_AW-1:0];
            end
          end
          OP_WRT: begin
            wv_nxt = r_r; wvalid_nxt = 1'b1;
          end
          OP_RED: begin
            rf_we = 1'b1; rf_wdata = rdv_r;
          end
          OP_HLT: halt_nxt = 1'b1;
          OP_NEG, OP_ADD, OP_SUB: begin
            rf_we = 1'b1; rf_wdata = alu_sum[WORD_W-1:0];
          end
          OP_MUL: begin
            rf_we = 1'b1; rf_wdata = mul_lo;
          end
          OP_DIV, OP_MOD: begin
            if (b_r == '0) begin
              rf_we     = 1'b1;
              fault_nxt = FAULT_DIV0;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = a_r;
              div_req.divisor  = b_r;
              state_nxt        = ST_DIV;
            end
          end
          OP_ODD: begin
            rf_we    = 1'b1;
            rf_wdata = !r_r[0] ? 32'd0 : (r_r[WORD_W-1] ? 32'hFFFF_FFFF : 32'd1);
          end
          OP_EQL: begin rf_we = 1'b1; rf_wdata = {31'd0, eq};        end
          OP_NEQ: begin rf_we = 1'b1; rf_wdata = {31'd0, !eq};       end
          OP_LSS: begin rf_we = 1'b1; rf_wdata = {31'd0, lt};        end
          OP_LEQ: begin rf_we = 1'b1; rf_wdata = {31'd0, lt || eq};  end
          OP_GTR: begin rf_we = 1'b1; rf_wdata = {31'd0, !lt && !eq}; end
          OP_GEQ: begin rf_we = 1'b1; rf_wdata = {31'd0, !lt};       end
          default: ;
        endcase
      end
      ST_WALK_RD: begin
        if (cnt_r == '0) begin
          state_nxt = (op_r == OP_CAL) ? ST_CAL_WR : ST_ADDR;
        end else if (base_r == STACK_LAST) begin
          fault_nxt = FAULT_STACK;
          rf_we     = (op_r == OP_LOD);
          state_nxt = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = base_r + 11'd1;
          state_nxt = ST_WALK_CHK;
        end
      end
      ST_WALK_CHK: begin
        if (mem_q[WORD_W-1:STACK_AW] != '0) begin
          fault_nxt = FAULT_STACK;
          rf_we     = (op_r == OP_LOD);
          state_nxt = ST_DONE;
        end else begin
          base_nxt  = mem_q[STACK_AW-1:0];
          cnt_nxt   = cnt_r - 4'd1;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_ADDR: begin
        state_nxt = ST_DONE;
        if (!in_rng) begin
          fault_nxt = FAULT_STACK;
          rf_we     = (op_r == OP_LOD);
        end else if (op_r == OP_LOD) begin
          mem_re    = 1'b1;
          mem_raddr = alu_sum[STACK_AW-1:0];
          state_nxt = ST_LOD_WAIT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = alu_sum[STACK_AW-1:0];
          mem_wdata = r_r;
        end
      end
      ST_LOD_WAIT: begin
        rf_we     = 1'b1;
        rf_wdata  = mem_q;
        state_nxt = ST_DONE;
      end
      ST_CAL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sp_r + 11'd1 + {9'd0, k_r};
        unique case (k_r)
          2'd0:    mem_wdata = '0;
          2'd1:    mem_wdata = {21'd0, base_r};
          2'd2:    mem_wdata = {21'd0, bp_r};
          default: mem_wdata = {23'd0, pc_r};
        endcase
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) begin
          bp_nxt    = sp_r + 11'd1;
          pc_nxt    = m_r[CODE_AW-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_RTN_RD3: begin
        if (mem_q[WORD_W-1:STACK_AW] != '0) begin
          fault_nxt = FAULT_STACK;
          state_nxt = ST_DONE;
        end else begin
          nb_nxt    = mem_q[STACK_AW-1:0];
          mem_re    = 1'b1;
          mem_raddr = bp_r + 11'd3;
          state_nxt = ST_RTN_FIN;
        end
      end
      ST_RTN_FIN: begin
        sp_nxt    = bp_r - 11'd1;
        bp_nxt    = nb_r;
        pc_nxt    = mem_q[CODE_AW-1:0];
        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          rf_we     = 1'b1;
          rf_wdata  = (op_r == OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the result beat once the output slot is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.program_counter = pc_r;
          out_data_nxt.base_pointer    = bp_r;
          out_data_nxt.stack_pointer   = sp_r;
          out_data_nxt.write_value     = wv_r;
          out_data_nxt.write_valid     = wvalid_r;
          out_data_nxt.halted          = halt_r;
          out_data_nxt.fault           = fault_r;
          state_nxt                    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= '0;
      sp_r        <= '0;
      bp_r        <= 11'd1;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pc_r        <= pc_nxt;
      sp_r        <= sp_nxt;
      bp_r        <= bp_nxt;
      halt_r      <= halt_nxt;
      out_valid_r <= out_valid_nxt;
      if (rf_we) begin
        rf_r[ri_r] <= rf_wdata;
      end
    end
  end

  // Instruction and working payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ri_r       <= ri_nxt;
    lv_r       <= lv_nxt;
    m_r        <= m_nxt;
    rdv_r      <= rdv_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    r_r        <= r_nxt;
    base_r     <= base_nxt;
    nb_r       <= nb_nxt;
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    wv_r       <= wv_nxt;
    wvalid_r   <= wvalid_nxt;
    fault_r    <= fault_nxt;
    out_data_r <= out_data_nxt;
  end

  // Stack memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  `RPE_ASSERT_NEXT(a_halt_sticky, halt_r && rst_n, halt_r, "halt flag dropped")
  `RPE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "beat taken while busy")
  `RPE_ASSERT_NOW(a_div_done_state, div_rsp.done, state_r == ST_DIV, "stray divider done")
  `RPE_ASSERT_NOW(a_div0_op, fault_r == FAULT_DIV0 && state_r == ST_DONE,
                  op_r == OP_DIV || op_r == OP_MOD, "divide fault on non-divide")

endmodule

@@ hw/rtl/rpe_div.sv @@
// ----------------------------------------------------------------------------
// rpe_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rpe_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rpe_pkg::div_req_t req,
  output rpe_pkg::div_rsp_t rsp
);
  import rpe_pkg::*;

  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] den_r, den_nxt;
  logic              qneg_r, qneg_nxt;
  logic              rneg_r, rneg_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W+1:0] trial;

  // Trial subtract of the shifted partial remainder
  assign trial = {1'b0, rem_r, quo_r[WORD_W-1]} - {2'b00, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend[WORD_W-1] ? (~req.dividend + 32'd1) : req.dividend;
      den_nxt  = req.divisor[WORD_W-1] ? (~req.divisor + 32'd1) : req.divisor;
      qneg_nxt = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
      rneg_nxt = req.dividend[WORD_W-1];
      cnt_nxt  = 6'd32;
    end else if (cnt_r != 6'd0) begin
      if (!trial[WORD_W+1]) begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  // Apply signs to the magnitudes
  assign rsp.done      = done_r;
  assign rsp.quotient  = qneg_r ? (~quo_r + 32'd1) : quo_r;
  assign rsp.remainder = rneg_r ? (~rem_r + 32'd1) : rem_r;

endmodule
